// ===== src/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// LBP package
// Shared constants, register indexes, ring table and result type for the
// 3x3 local binary pattern block.
// ----------------------------------------------------------------------------
package lbp_pkg;

  // Field widths of the stream and configuration ports.
  localparam int unsigned PIX_W      = 8;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COL_W      = 10;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 40;

  // Defaults and limits.
  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned FW_RST        = 400;
  localparam int unsigned FH_RST        = 400;
  localparam int unsigned MIN_DIM       = 3;
  localparam int unsigned OUT_DEPTH     = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Neighbor ring: window column (1 + dx) and row (1 + dy) for bit i,
  // starting at the right neighbor and turning toward the row below.
  localparam logic [1:0] RING_COL [8] = '{2'd2, 2'd2, 2'd1, 2'd0,
                                          2'd0, 2'd0, 2'd1, 2'd2};
  localparam logic [1:0] RING_ROW [8] = '{2'd1, 2'd2, 2'd2, 2'd2,
                                          2'd1, 2'd0, 2'd0, 2'd0};

  // One result as it sits in the output queue.
  typedef struct packed {
    logic                 last;
    logic [COL_W-1:0]     column;
    logic [ROW_W-1:0]     row;
    logic [CODE_W-1:0]    code;
  } lbp_result_t;

endpackage

// ===== src/lbp_ram.sv =====
// ----------------------------------------------------------------------------
// LBP generic RAM
// Simple dual-port RAM, one write and one read port, registered read data.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module lbp_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/lbp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// LBP output queue
// Small register queue that holds finished results until the master side
// takes them, and reports its fill level for input flow control.
// ----------------------------------------------------------------------------
module lbp_out_fifo #(
  parameter int unsigned Width = 35,
  parameter int unsigned Depth = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           push_data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       valid_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth+1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth-1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth-1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && do_pop) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/lbp_texture_code_3x3.sv =====
// ----------------------------------------------------------------------------
// 3x3 local binary pattern code
// Streams raster pixels through a two-row line store and a 3x3 window and emits
// the 8-neighbor LBP code of every interior pixel with its position.
// ----------------------------------------------------------------------------
// A result is pushed into the output queue in the cycle after its pixel
// is accepted and can be taken from the master side the cycle after.
// Throughput: one pixel per clock while the output queue has room, set by
// the line store, which takes one read and one write per cycle on its two ports.
// Reset (rst_ni low, asynchronous): clears the position counters, the window
// and the output queue; frame width and height return to 400. The line
// store is not cleared; stale entries only reach border pixels.
module lbp_texture_code_3x3
  import lbp_pkg::*;
#(
  parameter int unsigned MaxWidth = MAX_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Slave side: one pixel per request.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [PIX_W-1:0]      s_axis_tdata_i,   // [7:0] pixel
  input  logic                  s_axis_tuser_i,   // [0] frame_start
  // Master side: one LBP result per request.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [7:0] lbp_code, [23:8] row,
                                                  // [33:24] column, [39:34] zero
  output logic                  m_axis_tlast_o,   // last interior result of frame
  // Configuration write channel.
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Column counter and line store address width; the compare width holds
  // both the frame_width register and MaxWidth itself.
  localparam int unsigned ColW  = $clog2(MaxWidth);
  localparam int unsigned CmpW  = (ColW + 1 > FW_W) ? ColW + 1 : FW_W;
  localparam int unsigned CntW  = $clog2(OUT_DEPTH + 1);
  localparam int unsigned ResW  = $bits(lbp_result_t);
  localparam int unsigned WLastRst = ((FW_RST < MaxWidth) ? FW_RST : MaxWidth) - 1;
  localparam int unsigned HLastRst = FH_RST - 1;

  // --------------------------------------------------------------------------
  // Configuration. The registers are kept as "last column" and "last row"
  // of the frame, already clamped to their legal ranges, so the datapath
  // compares against them directly.
  // --------------------------------------------------------------------------
  logic [ColW-1:0] wlast_q, wlast_d;
  logic [FH_W-1:0] hlast_q, hlast_d;
  logic [CmpW-1:0] fw_ext;
  logic [FH_W-1:0] fh_val;
  logic            cfg_acc;

  assign cfg_ready_o = 1'b1;
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;
  assign fw_ext      = CmpW'(cfg_data_i[FW_W-1:0]);
  assign fh_val      = cfg_data_i[FH_W-1:0];

  always_comb begin
    wlast_d = wlast_q;
    hlast_d = hlast_q;
    if (cfg_acc) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH: begin
          if (fw_ext < CmpW'(MIN_DIM)) begin
            wlast_d = ColW'(MIN_DIM - 1);
          end else if (fw_ext > CmpW'(MaxWidth)) begin
            wlast_d = ColW'(MaxWidth - 1);
          end else begin
            wlast_d = ColW'(fw_ext - CmpW'(1));
          end
        end
        REG_FRAME_HEIGHT: begin
          if (fh_val < FH_W'(MIN_DIM)) begin
            hlast_d = FH_W'(MIN_DIM - 1);
          end else begin
            hlast_d = fh_val - FH_W'(1);
          end
        end
        default: begin
          // Writes to unknown indexes are accepted and dropped.
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlast_q <= ColW'(WLastRst);
      hlast_q <= FH_W'(HLastRst);
    end else begin
      wlast_q <= wlast_d;
      hlast_q <= hlast_d;
    end
  end

  // --------------------------------------------------------------------------
  // Input stage: raster position tracking and line store read.
  // frame_start forces the accepted pixel to row 0, column 0. The position
  // wraps after the last column of a row and after the last row of a frame.
  // --------------------------------------------------------------------------
  logic            s_acc;
  logic [ColW-1:0] col_q, col_d, col_cur;
  logic [ROW_W-1:0] row_q, row_d, row_cur;
  logic [CntW:0]   pending;

  // Each accepted pixel may produce one result; accept only while the queue
  // can hold the results of everything already in flight plus this pixel.
  logic [CntW-1:0] fifo_count;
  logic            vb_q;

  assign pending         = {1'b0, fifo_count} + (CntW+1)'(vb_q);
  assign s_axis_tready_o = (pending < (CntW+1)'(OUT_DEPTH));
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  assign col_cur = s_axis_tuser_i ? '0 : col_q;
  assign row_cur = s_axis_tuser_i ? '0 : row_q;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s_acc) begin
      if (col_cur >= wlast_q) begin
        col_d = '0;
        row_d = (row_cur >= hlast_q) ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_d = col_cur + ColW'(1);
        row_d = row_cur;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one entry per column holds the pixel two rows up (high byte)
  // and one row up (low byte). It is read when a pixel is accepted and
  // rewritten with the shifted pair in the following cycle.
  // --------------------------------------------------------------------------
  logic [2*PIX_W-1:0] ls_rdata;
  logic [2*PIX_W-1:0] ls_wdata;
  logic [2*PIX_W-1:0] ls_pair;

  // Second stage registers.
  logic [PIX_W-1:0]   px_b_q;
  logic [ColW-1:0]    col_b_q;
  logic [ROW_W-1:0]   row_b_q;
  logic               fwd_q;
  logic [2*PIX_W-1:0] fwd_data_q;

  lbp_ram #(
    .Width (2*PIX_W),
    .Depth (MaxWidth)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (vb_q),
    .waddr_i (col_b_q),
    .wdata_i (ls_wdata),
    .re_i    (s_acc),
    .raddr_i (col_cur),
    .rdata_o (ls_rdata)
  );

  // A read that lands on the column being written in the same cycle sees
  // the old entry, so the fresh pair is carried past the RAM instead. This
  // happens when a frame_start pixel directly follows one in column 0.
  assign ls_pair  = fwd_q ? fwd_data_q : ls_rdata;
  assign ls_wdata = {ls_pair[PIX_W-1:0], px_b_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q  <= 1'b0;
      fwd_q <= 1'b0;
    end else begin
      vb_q  <= s_acc;
      fwd_q <= s_acc && vb_q && (col_cur == col_b_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      px_b_q     <= s_axis_tdata_i;
      col_b_q    <= col_cur;
      row_b_q    <= row_cur;
      fwd_data_q <= ls_wdata;
    end
  end

  // --------------------------------------------------------------------------
  // Window and code. The window shifts left by one column per pixel; the new
  // right column is {two rows up, one row up, current}. The code is formed
  // from the shifted window, whose centre is the pixel one row up and one
  // column left of the current pixel.
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]  win_q [3][3];
  logic [PIX_W-1:0]  win_n [3][3];
  logic [CODE_W-1:0] code;
  logic [CmpW-1:0]   col_m1;
  logic              res_valid;
  lbp_result_t       res;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_n[k][0] = win_q[k][1];
      win_n[k][1] = win_q[k][2];
    end
    win_n[0][2] = ls_pair[2*PIX_W-1:PIX_W];
    win_n[1][2] = ls_pair[PIX_W-1:0];
    win_n[2][2] = px_b_q;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      code[i] = (win_n[RING_ROW[i]][RING_COL[i]] >= win_n[1][1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[k][j] <= '0;
        end
      end
    end else if (vb_q) begin
      win_q <= win_n;
    end
  end

  // Only interior centres give a result: the current pixel must be at least
  // two rows and two columns into the frame.
  assign res_valid  = vb_q && (row_b_q >= ROW_W'(2)) && (col_b_q >= ColW'(2));
  assign col_m1     = CmpW'(col_b_q) - CmpW'(1);
  assign res.code   = code;
  assign res.row    = row_b_q - ROW_W'(1);
  assign res.column = col_m1[COL_W-1:0];
  assign res.last   = (row_b_q >= hlast_q) && (col_b_q >= wlast_q);

  // --------------------------------------------------------------------------
  // Output queue: parts the master side from the datapath.
  // --------------------------------------------------------------------------
  logic [ResW-1:0] q_data;
  lbp_result_t     q_res;

  lbp_out_fifo #(
    .Width (ResW),
    .Depth (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .pop_i       (m_axis_tready_i),
    .data_o      (q_data),
    .valid_o     (m_axis_tvalid_o),
    .count_o     (fifo_count)
  );

  assign q_res          = lbp_result_t'(q_data);
  assign m_axis_tdata_o = {(OUT_DATA_W - CODE_W - ROW_W - COL_W)'(0),
                           q_res.column, q_res.row, q_res.code};
  assign m_axis_tlast_o = q_res.last;

endmodule

// ===== src/lbp_checker.sv =====
// ----------------------------------------------------------------------------
// LBP port checker
// Concurrent checks on the ports of the LBP block, attached by bind.
// ----------------------------------------------------------------------------
module lbp_checker
  import lbp_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                  m_axis_tlast_o
);

  logic s_acc;
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;

  // A stalled result request stays up with the same payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result request changed while stalled");

  // Results never describe a centre in row 0 or column 0.
  a_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[23:8] != 16'd0) &&
                        (m_axis_tdata_o[33:24] != 10'd0))
    else $error("result for a border pixel");

  // A result appearing on an empty output was caused by an accepted pixel
  // passing through the second stage and then the output queue.
  a_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_acc, 2))
    else $error("result without a matching pixel");

  // With no result waiting, the block must take pixels.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with an empty output");

endmodule

bind lbp_texture_code_3x3 lbp_checker u_lbp_checker (.*);
